@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BPFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bpfr_pkg.sv @@
// types, constants and helper functions of the bit pattern find and replace unit
// no dependencies
package bpfr_pkg;

    localparam int MAX_PATTERN       = 32;
    localparam int MAX_REPLACE       = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int LEN_W             = 6;
    localparam int POS_W             = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 3'd0,
        CFG_PBITS = 3'd1,
        CFG_PLEN = 3'd2,
        CFG_RBITS = 3'd3,
        CFG_RLEN = 3'd4
    } t_cfg_idx;

    // phases of the result sequencer
    typedef enum logic [1:0] {
        PH_EVICT,
        PH_MATCH,
        PH_REPL,
        PH_FLUSH
    } t_phase;

    typedef struct packed {
        logic             mode;
        logic [31:0]      pattern_bits;
        logic [LEN_W-1:0] pattern_length;
        logic [31:0]      replace_bits;
        logic [LEN_W-1:0] replace_length;
    } t_cfg;

    // one classified item, handed from front to back
    typedef struct packed {
        logic             evict;
        logic             evict_bit;
        logic             match;
        logic [POS_W-1:0] match_pos;
        logic [LEN_W-1:0] flush_len;
        logic [31:0]      flush_bits;
    } t_job;

    // pattern length clamped to 1..MAX_PATTERN and 32
    function automatic logic [LEN_W-1:0] eff_pat_len(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] r;
        r = n;
        if (r == '0) r = LEN_W'(1);
        if (32'(r) > MAX_PATTERN) r = LEN_W'(MAX_PATTERN);
        if (r > LEN_W'(32)) r = LEN_W'(32);
        return r;
    endfunction

    // replacement length clamped to MAX_REPLACE and 32
    function automatic logic [LEN_W-1:0] eff_rep_len(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] r;
        r = n;
        if (32'(r) > MAX_REPLACE) r = LEN_W'(MAX_REPLACE);
        if (r > LEN_W'(32)) r = LEN_W'(32);
        return r;
    endfunction

    // low n bits set
    function automatic logic [31:0] len_mask(input logic [LEN_W-1:0] n);
        logic [31:0] m;
        if (n >= LEN_W'(32)) m = '1;
        else m = (32'd1 << n[4:0]) - 32'd1;
        return m;
    endfunction

endpackage

@@ hdl/bpfr_front.sv @@
// front part: window, bit position and match detection per input item
// depends on bpfr_pkg
module bpfr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic            i_bit_value,
    input  logic            i_last_bit,
    input  bpfr_pkg::t_cfg  i_cfg,
    input  logic            i_len_wr,
    input  logic            i_q_full,
    output logic            o_q_push,
    output bpfr_pkg::t_job  o_q_data
);
    import bpfr_pkg::*;

    logic [31:0]      r_window, n_window;
    logic [LEN_W-1:0] r_wcount, n_wcount;
    logic [POS_W-1:0] r_bit_index, n_bit_index;

    logic             accept;
    logic             rep;
    logic             win_full;
    logic             hit;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] wc1, wc2, wc3;
    logic [31:0]      w1, w2, w3;
    logic [POS_W-1:0] idx1;
    t_job             job;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    // classify the item against the window
    always_comb begin
        plen     = eff_pat_len(i_cfg.pattern_length);
        rep      = i_cfg.mode;
        idx1     = r_bit_index + POS_W'(1);
        win_full = (r_wcount >= plen);
        w1       = win_full ? (r_window >> 1) : r_window;
        wc1      = win_full ? LEN_W'(plen - LEN_W'(1)) : r_wcount;
        w2       = w1 | ({31'b0, i_bit_value} << wc1[4:0]);
        wc2      = wc1 + LEN_W'(1);
        hit      = (wc2 == plen) && (w2 == (i_cfg.pattern_bits & len_mask(plen)));
        w3       = hit ? '0 : w2;
        wc3      = hit ? '0 : wc2;

        job.evict      = win_full && rep;
        job.evict_bit  = r_window[0];
        job.match      = hit;
        job.match_pos  = idx1 - POS_W'(plen) + POS_W'(1);
        job.flush_len  = (rep && i_last_bit) ? wc3 : '0;
        job.flush_bits = w3;
    end

    assign o_q_data = job;
    assign o_q_push = accept && (job.evict || job.match || (job.flush_len != '0));

    // window update
    always_comb begin
        n_window    = r_window;
        n_wcount    = r_wcount;
        n_bit_index = r_bit_index;
        if (i_len_wr) begin
            n_window = '0;
            n_wcount = '0;
        end else if (accept) begin
            if (i_last_bit) begin
                n_window    = '0;
                n_wcount    = '0;
                n_bit_index = '0;
            end else begin
                n_window    = w3;
                n_wcount    = wc3;
                n_bit_index = idx1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_wcount    <= '0;
            r_bit_index <= '0;
        end else begin
            r_window    <= n_window;
            r_wcount    <= n_wcount;
            r_bit_index <= n_bit_index;
        end
    end

endmodule

@@ hdl/bpfr_queue.sv @@
// short first-in first-out queue of classified items between front and back
// depends on bpfr_pkg
module bpfr_queue #(
    parameter int P_DEPTH = bpfr_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bpfr_pkg::t_job  i_data,
    output logic            o_full,
    output logic            o_valid,
    output bpfr_pkg::t_job  o_data,
    input  logic            i_pop
);
    import bpfr_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_job             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) n_wr = (r_wr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        if (do_pop)  n_rd = (r_rd == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        if (do_push && !do_pop) n_count = r_count + CNT_W'(1);
        else if (do_pop && !do_push) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

@@ hdl/bpfr_back.sv @@
// back part: expands each classified item into result items, output register
// depends on bpfr_pkg
module bpfr_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bpfr_pkg::t_cfg           i_cfg,
    input  logic                     i_job_valid,
    input  bpfr_pkg::t_job           i_job,
    output logic                     o_job_pop,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic                     o_kind,
    output logic                     o_out_bit,
    output logic [bpfr_pkg::POS_W-1:0] o_match_position,
    output logic                     o_last_result
);
    import bpfr_pkg::*;

    t_phase           r_phase, n_phase;
    t_phase           cur;
    t_phase           step_phase;
    logic [LEN_W-1:0] r_k, n_k;
    logic [LEN_W-1:0] step_k;
    logic [LEN_W-1:0] rlen;
    logic             step_done;
    logic             has_r, has_f;
    logic             advance;
    logic             res_kind, res_bit;
    logic [POS_W-1:0] res_pos;

    logic             r_out_valid;
    logic             r_kind, r_bit, r_last;
    logic [POS_W-1:0] r_pos;

    assign advance   = i_job_valid && (!r_out_valid || i_pop);
    assign o_job_pop = advance && step_done;

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EVICT;
            r_k     <= '0;
        end else begin
            r_phase <= n_phase;
            r_k     <= n_k;
        end
    end

    // next phase and the result of this step
    always_comb begin
        rlen       = eff_rep_len(i_cfg.replace_length);
        has_r      = i_job.match && i_cfg.mode && (rlen != '0);
        has_f      = (i_job.flush_len != '0);
        res_kind   = 1'b0;
        res_bit    = 1'b0;
        res_pos    = '0;
        step_phase = r_phase;
        step_k     = r_k;
        step_done  = 1'b0;

        // an item with no evicted bit opens with its report or its flush
        if (r_phase == PH_EVICT && !i_job.evict) cur = i_job.match ? PH_MATCH : PH_FLUSH;
        else cur = r_phase;

        unique case (cur)
            PH_EVICT: begin
                res_bit = i_job.evict_bit;
                if (i_job.match) step_phase = PH_MATCH;
                else if (has_f) step_phase = PH_FLUSH;
                else step_done = 1'b1;
            end
            PH_MATCH: begin
                res_kind = 1'b1;
                res_pos  = i_job.match_pos;
                if (has_r) step_phase = PH_REPL;
                else if (has_f) step_phase = PH_FLUSH;
                else step_done = 1'b1;
            end
            PH_REPL: begin
                res_bit = i_cfg.replace_bits[r_k[4:0]];
                if (r_k == LEN_W'(rlen - LEN_W'(1))) begin
                    step_k = '0;
                    if (has_f) step_phase = PH_FLUSH;
                    else step_done = 1'b1;
                end else begin
                    step_k = r_k + LEN_W'(1);
                end
            end
            PH_FLUSH: begin
                res_bit = i_job.flush_bits[r_k[4:0]];
                if (r_k == LEN_W'(i_job.flush_len - LEN_W'(1))) step_done = 1'b1;
                else step_k = r_k + LEN_W'(1);
            end
            default: step_done = 1'b1;
        endcase

        n_phase = r_phase;
        n_k     = r_k;
        if (advance) begin
            if (step_done) begin
                n_phase = PH_EVICT;
                n_k     = '0;
            end else begin
                n_phase = step_phase;
                n_k     = step_k;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind <= res_kind;
            r_bit  <= res_bit;
            r_pos  <= res_pos;
            r_last <= step_done;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_kind           = r_kind;
    assign o_out_bit        = r_bit;
    assign o_match_position = r_pos;
    assign o_last_result    = r_last;

endmodule

@@ hdl/bit_pattern_find_replace_unit.sv @@
// Bit pattern find and replace unit, top level.
// Input queue side: push/full carries one stream bit per item with a last-bit
// flag; an item is taken at an edge with push high and full low.
// Result queue side: empty/pop; the oldest result sits on the result ports while
// empty is low and leaves at an edge with pop high. kind 1 is a match report
// with its 1-based start position, kind 0 a data bit of the replaced stream.
// last_result marks the final result caused by one input item.
// Configuration: i_cfg_we/i_cfg_index/i_cfg_data, to be written only while idle;
// the block does not enforce this; writing the pattern length empties the window.
// Throughput: one item per cycle while each item causes at most one result and pop
// keeps up; an item causing more results holds the result sequencer while it emits
// them, and a four-entry queue between classifier and sequencer absorbs short bursts.
// The first result of an item passes the queue and then the output register on its
// way to the result ports.
// Reset clears the window, position, queue and output register, and loads the
// register defaults. When pop stays low the output register holds its result,
// the queue fills, and full then stalls the input side.
// depends on bpfr_pkg, bpfr_front, bpfr_queue, bpfr_back, assert_macros.svh
`include "assert_macros.svh"

module bit_pattern_find_replace_unit #(
    parameter int P_QUEUE_DEPTH = bpfr_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_bit_value,
    input  logic                          i_last_bit,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_kind,
    output logic                          o_out_bit,
    output logic [bpfr_pkg::POS_W-1:0]    o_match_position,
    output logic                          o_last_result,
    input  logic                          i_cfg_we,
    input  logic [bpfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bpfr_pkg::*;

    t_cfg r_cfg;
    logic len_wr;
    logic q_push, q_full, q_valid, q_pop;
    t_job q_in, q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= 1'b0;
            r_cfg.pattern_bits   <= '0;
            r_cfg.pattern_length <= LEN_W'(1);
            r_cfg.replace_bits   <= '0;
            r_cfg.replace_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_cfg.mode           <= i_cfg_data[0];
                CFG_PBITS: r_cfg.pattern_bits   <= i_cfg_data[31:0];
                CFG_PLEN:  r_cfg.pattern_length <= i_cfg_data[LEN_W-1:0];
                CFG_RBITS: r_cfg.replace_bits   <= i_cfg_data[31:0];
                CFG_RLEN:  r_cfg.replace_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_wr = i_cfg_we && (i_cfg_index == CFG_PLEN);

    bpfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_bit_value (i_bit_value),
        .i_last_bit  (i_last_bit),
        .i_cfg       (r_cfg),
        .i_len_wr    (len_wr),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    bpfr_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    bpfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_job_valid      (q_valid),
        .i_job            (q_out),
        .o_job_pop        (q_pop),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_kind           (o_kind),
        .o_out_bit        (o_out_bit),
        .o_match_position (o_match_position),
        .o_last_result    (o_last_result)
    );

    // result checks
    `BPFR_ASSERT_IMPL(a_report_no_bit, i_clk, i_rst_n, !empty && o_kind, !o_out_bit, "match report carries a data bit")
    `BPFR_ASSERT_IMPL(a_data_no_pos, i_clk, i_rst_n, !empty && !o_kind, o_match_position == '0, "data bit carries a position")
    `BPFR_ASSERT_NEXT(a_burst_gapless, i_clk, i_rst_n, pop && !empty && !o_last_result, !empty, "gap inside the results of one item")

endmodule

@@ tb/bit_pattern_find_replace_unit_test.sv @@
// self-checking testbench for the bit pattern find and replace unit
// a predictor tracks window, position and registers per accepted item
// depends on bpfr_pkg and bit_pattern_find_replace_unit
module bit_pattern_find_replace_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfr_pkg::*;

    // spare register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD_CYCLES = 120;

    typedef struct packed {
        logic b;
        logic last;
    } t_stream_bit;

    typedef struct packed {
        logic             kind;
        logic             out_bit;
        logic [POS_W-1:0] pos;
        logic             last_res;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_bit_value = 1'b0;
    logic                  i_last_bit = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_kind;
    logic                  o_out_bit;
    logic [POS_W-1:0]      o_match_position;
    logic                  o_last_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // items waiting to be offered and results waiting to arrive
    t_stream_bit bits_to_send[$];
    t_result     expected_results[$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    // predictor copy of the registers and the stream state
    logic             cfg_mode = 1'b0;
    logic [31:0]      cfg_pbits = '0;
    logic [LEN_W-1:0] cfg_plen = LEN_W'(1);
    logic [31:0]      cfg_rbits = '0;
    logic [LEN_W-1:0] cfg_rlen = '0;
    logic [31:0]      held_bits = '0;
    int               held_count = 0;
    logic [POS_W-1:0] stream_pos = '0;

    bit_pattern_find_replace_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_bit_value     (i_bit_value),
        .i_last_bit      (i_last_bit),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_out_bit       (o_out_bit),
        .o_match_position(o_match_position),
        .o_last_result   (o_last_result),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pattern length as the block uses it
    function automatic int clamp_pattern_len(input logic [LEN_W-1:0] n);
        int r;
        r = n;
        if (r < 1) r = 1;
        if (r > 32) r = 32;
        return r;
    endfunction

    // expected results of one stream bit, in emission order
    task automatic find_replace_step(input t_stream_bit item);
        t_result     res[$];
        int          plen_eff;
        int          rlen_eff;
        int          k;
        logic [31:0] mask;
        plen_eff = clamp_pattern_len(cfg_plen);
        rlen_eff = (cfg_rlen > 32) ? 32 : cfg_rlen;
        mask = (plen_eff >= 32) ? '1 : ((32'd1 << plen_eff) - 32'd1);
        stream_pos = stream_pos + 1;

        // window full: oldest bit leaves
        if (held_count >= plen_eff) begin
            if (cfg_mode) res.insert(res.size(), '{1'b0, held_bits[0], '0, 1'b0});
            held_bits = held_bits >> 1;
            held_count = plen_eff - 1;
        end
        held_bits[held_count] = item.b;
        held_count++;

        // match: report, then replacement, window dropped
        if (held_count == plen_eff && (held_bits & mask) == (cfg_pbits & mask)) begin
            res.insert(res.size(), '{1'b1, 1'b0, stream_pos - POS_W'(plen_eff) + 1, 1'b0});
            if (cfg_mode) begin
                for (k = 0; k < rlen_eff; k++) begin
                    res.insert(res.size(), '{1'b0, cfg_rbits[k], '0, 1'b0});
                end
            end
            held_bits = '0;
            held_count = 0;
        end

        // end of stream: flush what is held and restart the position
        if (item.last) begin
            if (cfg_mode) begin
                for (k = 0; k < held_count; k++) begin
                    res.insert(res.size(), '{1'b0, held_bits[k], '0, 1'b0});
                end
            end
            held_bits = '0;
            held_count = 0;
            stream_pos = '0;
        end

        if (res.size() > 0) begin
            res[res.size() - 1].last_res = 1'b1;
        end
        foreach (res[i]) expected_results.insert(expected_results.size(), res[i]);
    endtask

    // sender: offers the front item at random, changes at the falling edge
    always @(negedge i_clk) begin
        if (bits_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            push <= 1'b1;
            i_bit_value <= bits_to_send[0].b;
            i_last_bit <= bits_to_send[0].last;
        end else begin
            push <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // accepted item: predict its results
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            find_replace_step(bits_to_send.pop_front());
        end
    end

    // accepted result: compare with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && pop && !empty) begin
            got.kind = o_kind;
            got.out_bit = o_out_bit;
            got.pos = o_match_position;
            got.last_res = o_last_result;
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result kind %0d bit %0d pos %0d last %0d",
                         $time, got.kind, got.out_bit, got.pos, got.last_res);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch, expected kind %0d bit %0d pos %0d last %0d",
                             $time, want.kind, want.out_bit, want.pos, want.last_res);
                    $display("%0t:           actual   kind %0d bit %0d pos %0d last %0d",
                             $time, got.kind, got.out_bit, got.pos, got.last_res);
                end
            end
        end
    end

    // one register write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE: cfg_mode = data[0];
            CFG_PBITS: cfg_pbits = data;
            CFG_PLEN: begin
                cfg_plen = data[LEN_W-1:0];
                held_bits = '0;
                held_count = 0;
            end
            CFG_RBITS: cfg_rbits = data;
            CFG_RLEN: cfg_rlen = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every item is taken and every result has arrived
    task automatic settle();
        while (bits_to_send.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_bits(input logic [31:0] bits, input int n, input logic end_stream);
        int k;
        for (k = 0; k < n; k++) begin
            bits_to_send.insert(bits_to_send.size(), '{bits[k], end_stream && k == n - 1});
        end
    endtask

    // well-formed stream: mostly pattern copies, some corrupted copies and noise
    task automatic queue_stream(input int n_items, input logic end_stream);
        int          sent;
        int          k;
        int          len;
        int          plen_eff;
        int          flip_at;
        logic [31:0] chunk;
        logic        lst;
        plen_eff = clamp_pattern_len(cfg_plen);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 60) begin
                chunk = cfg_pbits;
                len = plen_eff;
                if ($urandom_range(99) < 15) begin
                    flip_at = $urandom_range(len - 1);
                    chunk[flip_at] = ~chunk[flip_at];
                end
            end else begin
                chunk = $urandom;
                len = $urandom_range((plen_eff + 2 > 32) ? 32 : plen_eff + 2, 1);
            end
            for (k = 0; k < len && sent < n_items; k++) begin
                sent++;
                if (sent == n_items) lst = end_stream;
                else lst = (k == len - 1) && ($urandom_range(99) < 10);
                bits_to_send.insert(bits_to_send.size(), '{chunk[k], lst});
            end
        end
    endtask

    // stimulus sequence
    initial begin
        int          ph;
        int          idx;
        logic        mode_v;
        logic [5:0]  plen_v;
        logic [5:0]  rlen_v;
        logic [31:0] pbits_v;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: report mode, single-bit pattern of zero
        send_bits(32'b010, 3, 1'b1);
        settle();

        // pattern length zero acts as one, two-bit replacement per match
        write_reg(CFG_MODE, 32'({$urandom, 1'b1}));
        write_reg(CFG_PBITS, 32'hFFFF_FFFD);
        write_reg(CFG_PLEN, 32'({$urandom, 6'd0}));
        write_reg(CFG_RBITS, 32'h0000_0002);
        write_reg(CFG_RLEN, 32'({$urandom, 6'd2}));
        send_bits(32'b101, 3, 1'b1);
        settle();

        // three-bit pattern, empty replacement deletes the match, flush at the end
        write_reg(CFG_PLEN, 32'({$urandom, 6'd3}));
        write_reg(CFG_PBITS, 32'h0000_0005);
        write_reg(CFG_RLEN, 32'({$urandom, 6'd0}));
        send_bits(32'b1101011, 7, 1'b1);
        settle();

        // oversized lengths saturate, short stream flushed
        write_reg(CFG_PLEN, 32'({$urandom, 6'd63}));
        write_reg(CFG_PBITS, 32'hFFFF_FFFF);
        write_reg(CFG_RBITS, $urandom);
        write_reg(CFG_RLEN, 32'({$urandom, 6'd63}));
        send_bits(32'b0100, 4, 1'b1);
        settle();

        // report mode flush emits nothing
        write_reg(CFG_MODE, 32'({$urandom, 1'b0}));
        write_reg(CFG_PLEN, 32'({$urandom, 6'd2}));
        write_reg(CFG_PBITS, 32'h0000_0002);
        send_bits(32'b110, 3, 1'b1);
        settle();

        // spare indexes change nothing; one- and two-item streams
        for (idx = CFG_SPARE_LO; idx <= CFG_SPARE_HI; idx++) begin
            write_reg(CFG_IDX_W'(idx), $urandom);
        end
        write_reg(CFG_MODE, 32'({$urandom, 1'b1}));
        send_bits(32'b1, 1, 1'b1);
        send_bits(32'b10, 2, 1'b1);
        settle();

        // random phases over idle patterns and register settings
        for (ph = 0; ph < 8; ph++) begin
            settle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            mode_v = ($urandom_range(99) < 75);
            pbits_v = $urandom;
            plen_v = 6'($urandom_range(8, 1));
            rlen_v = 6'($urandom_range(6, 0));
            case (ph)
                0: begin mode_v = 1'b1; plen_v = 6'd32; rlen_v = 6'd32; end
                1: begin mode_v = 1'b1; plen_v = 6'd63; rlen_v = 6'd63; end
                2: begin mode_v = 1'b0; plen_v = 6'd0; end
                3: begin mode_v = 1'b1; plen_v = 6'd1; rlen_v = 6'd0; end
                4: begin mode_v = 1'b1; plen_v = 6'd2; rlen_v = 6'd3; end
                5: pbits_v = '1;
                6: pbits_v = '0;
                default: ;
            endcase
            write_reg(CFG_MODE, 32'({$urandom, mode_v}));
            write_reg(CFG_PBITS, pbits_v);
            write_reg(CFG_PLEN, 32'({$urandom, plen_v}));
            write_reg(CFG_RBITS, $urandom);
            write_reg(CFG_RLEN, 32'({$urandom, rlen_v}));
            queue_stream((clamp_pattern_len(plen_v) >= 16) ? 45 : 27, 1'($urandom_range(1)));
            // receiver holds off while the sender keeps offering
            if (ph == 4) begin
                @(posedge i_clk);
                hold_req = LONG_HOLD_CYCLES;
                @(posedge i_clk);
                hold_req = 0;
            end
        end

        settle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
